// ===== design/sabp_pkg.sv =====
// Package: constants, types and helpers shared by the scaled alpha blit pixel engine.
`timescale 1ns / 1ps
`default_nettype none
package sabp_pkg;
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned MaxStride = 8192;

  localparam int unsigned RegIdxW = 3;
  typedef enum logic [RegIdxW-1:0] {
    REG_SRC_W   = 3'd0,
    REG_SRC_H   = 3'd1,
    REG_DST_L   = 3'd2,
    REG_DST_T   = 3'd3,
    REG_DST_W   = 3'd4,
    REG_DST_H   = 3'd5,
    REG_STRIDE  = 3'd6,
    REG_CH_ORD  = 3'd7
  } reg_idx_e;

  localparam logic REQ_ADDR  = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] AlphaClear  = 8'h00;

  // Pixel classification made by the front end.
  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_COPY  = 2'd1,
    PK_BLEND = 2'd2
  } pix_kind_e;

  // Output payload.
  typedef struct packed {
    logic        we;
    logic [31:0] pixel;
    logic [25:0] dst_index;
    logic [23:0] src_index;
  } res_t;

  // Exact floor divide by 255 of a value below 65280 (8-bit result): (v+1+(v>>8))>>8.
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [17:0] t;
    t = {1'b0, v} + 18'd1 + {9'd0, v[16:8]};
    return t[15:8];
  endfunction
endpackage
`default_nettype wire

// ===== design/scaled_alpha_blit_pixel.sv =====
// Top level: registers, step dividers and the front/back pixel pipeline.
//
// Usage: configure via cfg_valid_i/cfg_index_i/cfg_data_i while idle. The
// cycle after each write a step divider restarts and recomputes
// (source << 16) / dest in 29 iterations per axis; s_axis_tready stays low
// until it finishes (also after reset).
// Items enter on s_axis (tdata: col, row, src_color, bg_color; tuser:
// req_type) and results leave on m_axis (tdata: src_index, dst_index, pixel;
// tuser: write_enable). One item per cycle is accepted while s_axis_tready
// is high; items pass front stages 1 and 2, then back stage A, to the output
// register, whose spare lets a stalled receiver halt the pipeline one stage
// at a time with no item lost; on release the spare drains first at the cost of
// one input bubble. Reset loads the register defaults and empties all stages.
`timescale 1ns / 1ps
`default_nettype none
module scaled_alpha_blit_pixel #(
  parameter int unsigned MAX_DIM    = sabp_pkg::MaxDim,
  parameter int unsigned MAX_STRIDE = sabp_pkg::MaxStride
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: col[11:0], row[23:12], src_color[55:24], bg_color[87:56]
  input  wire logic [87:0]  s_axis_tdata,
  // tuser: req_type
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: src_index[23:0], dst_index[49:24], pixel[81:50], pad zeros
  output logic [87:0]       m_axis_tdata,
  // tuser: write_enable
  output logic [0:0]        m_axis_tuser
);
  import sabp_pkg::*;
  localparam int unsigned DW = $clog2(MAX_DIM) + 1;
  localparam int unsigned SW = $clog2(MAX_STRIDE) + 1;
  localparam int unsigned NW = DW + 16;

  logic [12:0] sw_q, sh_q, dw_q, dh_q;
  logic [11:0] dl_q, dt_q;
  logic [13:0] st_q;
  logic        ord_q;
  logic        cfg_wr_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 13'd1; sh_q <= 13'd1; dw_q <= 13'd1; dh_q <= 13'd1;
      dl_q <= '0; dt_q <= '0; st_q <= 14'd1; ord_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SRC_W:  sw_q  <= cfg_data_i[12:0];
        REG_SRC_H:  sh_q  <= cfg_data_i[12:0];
        REG_DST_L:  dl_q  <= cfg_data_i[11:0];
        REG_DST_T:  dt_q  <= cfg_data_i[11:0];
        REG_DST_W:  dw_q  <= cfg_data_i[12:0];
        REG_DST_H:  dh_q  <= cfg_data_i[12:0];
        REG_STRIDE: st_q  <= cfg_data_i[13:0];
        REG_CH_ORD: ord_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Flag a write so the dividers restart from the updated registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_wr_q <= 1'b0;
    else cfg_wr_q <= cfg_valid_i && cfg_ready_o;
  end

  // Saturate dimensions.
  function automatic logic [DW-1:0] dsat(input logic [12:0] v);
    if (v == 13'd0) return DW'(1);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction
  logic [DW-1:0] s_w, s_h, d_w, d_h;
  logic [SW-1:0] strd;
  assign s_w  = dsat(sw_q);
  assign s_h  = dsat(sh_q);
  assign d_w  = dsat(dw_q);
  assign d_h  = dsat(dh_q);
  assign strd = (32'(st_q) > MAX_STRIDE) ? SW'(MAX_STRIDE) : SW'(st_q);

  // Restoring dividers for the two steps, restart after any config write.
  logic [NW-1:0] qx_q, qy_q, nx_q, ny_q;
  logic [DW:0]   rx_q, ry_q;
  logic [$clog2(NW+1)-1:0] cnt_q;
  logic [DW:0]   rxs, rys;
  logic [DW+1:0] tx, ty;
  logic          step_busy;
  assign rxs = {rx_q[DW-1:0], nx_q[NW-1]};
  assign rys = {ry_q[DW-1:0], ny_q[NW-1]};
  assign tx  = {1'b0, rxs} - {2'b0, d_w};
  assign ty  = {1'b0, rys} - {2'b0, d_h};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      qx_q <= '0; qy_q <= '0; nx_q <= '0; ny_q <= '0; rx_q <= '0; ry_q <= '0;
    end else if (cfg_wr_q || (cnt_q == '0 && qx_q == '0)) begin
      cnt_q <= ($clog2(NW+1))'(NW);
      nx_q  <= {s_w, 16'd0};
      ny_q  <= {s_h, 16'd0};
      rx_q  <= '0; ry_q <= '0;
      qx_q  <= '0; qy_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      nx_q  <= {nx_q[NW-2:0], 1'b0};
      ny_q  <= {ny_q[NW-2:0], 1'b0};
      rx_q  <= tx[DW+1] ? rxs : tx[DW:0];
      ry_q  <= ty[DW+1] ? rys : ty[DW:0];
      qx_q  <= {qx_q[NW-2:0], ~tx[DW+1]};
      qy_q  <= {qy_q[NW-2:0], ~ty[DW+1]};
    end
  end

  // Hold off items until the steps are valid.
  assign step_busy = cfg_wr_q || (cnt_q != '0) || (qx_q == '0);

  logic              q_valid, q_ready, f_ord, f_in_ready;
  logic [DW-1:0]     f_sx, f_sy;
  logic [25:0]       f_rb, f_off;
  logic [31:0]       f_src, f_bg;
  pix_kind_e         f_kind;
  res_t              res;

  assign s_axis_tready = f_in_ready && !step_busy;

  sabp_front #(.MAX_DIM(MAX_DIM), .MAX_STRIDE(MAX_STRIDE)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid && !step_busy), .in_ready_o(f_in_ready),
    .req_type_i(s_axis_tuser[0]), .col_i(s_axis_tdata[11:0]),
    .row_i(s_axis_tdata[23:12]), .src_color_i(s_axis_tdata[55:24]),
    .bg_color_i(s_axis_tdata[87:56]),
    .src_w_i(s_w), .src_h_i(s_h),
    .stride_i(strd), .dst_l_i(dl_q), .dst_t_i(dt_q), .ch_ord_i(ord_q),
    .step_x_i(qx_q), .step_y_i(qy_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready),
    .sx_o(f_sx), .sy_o(f_sy), .row_base_o(f_rb), .dst_off_o(f_off),
    .src_o(f_src), .bg_o(f_bg), .ch_ord_o(f_ord), .kind_o(f_kind)
  );

  sabp_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .sx_i(f_sx), .sy_i(f_sy), .src_w_i(s_w), .row_base_i(f_rb),
    .dst_off_i(f_off), .src_i(f_src), .bg_i(f_bg), .ch_ord_i(f_ord),
    .kind_i(f_kind),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.pixel, res.dst_index, res.src_index};
  assign m_axis_tuser = res.we;
endmodule
`default_nettype wire

// ===== design/sabp_front.sv =====
// Front end: takes items, computes sample positions per item and classifies the pixel.
`timescale 1ns / 1ps
`default_nettype none
module sabp_front #(
  parameter int unsigned MAX_DIM    = sabp_pkg::MaxDim,
  parameter int unsigned MAX_STRIDE = sabp_pkg::MaxStride,
  localparam int unsigned DW = $clog2(MAX_DIM) + 1,
  localparam int unsigned SW = $clog2(MAX_STRIDE) + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          req_type_i,
  input  wire logic [11:0]   col_i,
  input  wire logic [11:0]   row_i,
  input  wire logic [31:0]   src_color_i,
  input  wire logic [31:0]   bg_color_i,
  input  wire logic [DW-1:0] src_w_i,
  input  wire logic [DW-1:0] src_h_i,
  input  wire logic [SW-1:0] stride_i,
  input  wire logic [11:0]   dst_l_i,
  input  wire logic [11:0]   dst_t_i,
  input  wire logic          ch_ord_i,
  input  wire logic [DW+15:0] step_x_i,
  input  wire logic [DW+15:0] step_y_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output logic [DW-1:0]      sx_o,
  output logic [DW-1:0]      sy_o,
  output logic [25:0]        row_base_o,
  output logic [25:0]        dst_off_o,
  output logic [31:0]        src_o,
  output logic [31:0]        bg_o,
  output logic               ch_ord_o,
  output sabp_pkg::pix_kind_e kind_o
);
  import sabp_pkg::*;

  // Stage 1: register item and multiply by steps and stride.
  logic              s1_v_q;
  logic [DW+27:0]    px_q, py_q;
  logic [25:0]       rb_q, off_q;
  logic [31:0]       src_q, bg_q;
  logic              req_q, ord_q;
  logic [DW-1:0]     sw_q, sh_q;
  logic              s1_adv;

  assign s1_adv     = !s1_v_q || !q_valid_o || q_ready_i;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (s1_adv) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      px_q  <= {{DW{1'b0}}, 16'd0, col_i} * {12'd0, step_x_i};
      py_q  <= {{DW{1'b0}}, 16'd0, row_i} * {12'd0, step_y_i};
      rb_q  <= 26'({13'd0, 13'({1'b0, dst_t_i} + {1'b0, row_i})} * 26'(stride_i));
      off_q <= 26'({1'b0, dst_l_i} + {1'b0, col_i});
      src_q <= src_color_i;
      bg_q  <= bg_color_i;
      req_q <= req_type_i;
      ord_q <= ch_ord_i;
      sw_q  <= src_w_i;
      sh_q  <= src_h_i;
    end
  end

  // Stage 2: clamp sample position and classify.
  logic [DW+11:0] xs, ys;
  assign xs = px_q[DW+27:16];
  assign ys = py_q[DW+27:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) q_valid_o <= 1'b0;
    else if (!q_valid_o || q_ready_i) q_valid_o <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if ((!q_valid_o || q_ready_i) && s1_v_q) begin
      sx_o       <= (xs >= (DW+12)'(sw_q)) ? DW'(sw_q - 1'b1) : xs[DW-1:0];
      sy_o       <= (ys >= (DW+12)'(sh_q)) ? DW'(sh_q - 1'b1) : ys[DW-1:0];
      row_base_o <= rb_q;
      dst_off_o  <= off_q;
      src_o      <= src_q;
      bg_o       <= bg_q;
      ch_ord_o   <= ord_q;
      if (req_q != REQ_BLEND || src_q[31:24] == AlphaClear) kind_o <= PK_NONE;
      else if (src_q[31:24] == AlphaOpaque) kind_o <= PK_COPY;
      else kind_o <= PK_BLEND;
    end
  end
endmodule
`default_nettype wire

// ===== design/sabp_back.sv =====
// Back end: index sums, channel blend and output register with skid buffer.
`timescale 1ns / 1ps
`default_nettype none
module sabp_back #(
  parameter int unsigned MAX_DIM = sabp_pkg::MaxDim,
  localparam int unsigned DW = $clog2(MAX_DIM) + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire logic [DW-1:0]     sx_i,
  input  wire logic [DW-1:0]     sy_i,
  input  wire logic [DW-1:0]     src_w_i,
  input  wire logic [25:0]       row_base_i,
  input  wire logic [25:0]       dst_off_i,
  input  wire logic [31:0]       src_i,
  input  wire logic [31:0]       bg_i,
  input  wire logic              ch_ord_i,
  input  wire sabp_pkg::pix_kind_e kind_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sabp_pkg::res_t         res_o
);
  import sabp_pkg::*;

  // Stage A: products for index and blend.
  logic          a_v_q;
  logic [2*DW-1:0] sidx_q;
  logic [DW-1:0] sx_q;
  logic [25:0]   didx_q;
  logic [16:0]   pr_q, pg_q, pb_q;
  logic [7:0]    r_q, g_q, b_q;
  logic          ord_q;
  pix_kind_e     kind_q;
  logic          a_adv;
  logic [7:0]    a, na, br, bb, bgg;

  assign a   = src_i[31:24];
  assign na  = 8'hFF - a;
  assign bgg = bg_i[15:8];
  assign br  = ch_ord_i ? bg_i[23:16] : bg_i[7:0];
  assign bb  = ch_ord_i ? bg_i[7:0] : bg_i[23:16];

  // Output skid: main and spare register.
  logic   o_v_q, sk_v_q;
  res_t   o_q, sk_q;
  assign a_adv     = !a_v_q || !sk_v_q;
  assign q_ready_o = a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (a_adv) a_v_q <= q_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && q_valid_i) begin
      sidx_q <= sy_i * src_w_i;
      sx_q   <= sx_i;
      didx_q <= row_base_i + dst_off_i;
      pr_q   <= 17'(16'(src_i[7:0] * a) + 16'(br * na)) + 17'd127;
      pg_q   <= 17'(16'(src_i[15:8] * a) + 16'(bgg * na)) + 17'd127;
      pb_q   <= 17'(16'(src_i[23:16] * a) + 16'(bb * na)) + 17'd127;
      r_q    <= src_i[7:0];
      g_q    <= src_i[15:8];
      b_q    <= src_i[23:16];
      ord_q  <= ch_ord_i;
      kind_q <= kind_i;
    end
  end

  // Stage B: finish result.
  res_t        nres;
  logic [7:0]  fr, fg, fb;
  logic [2*DW:0] sid_sum;
  assign sid_sum = {1'b0, sidx_q} + (2*DW+1)'(sx_q);
  always_comb begin
    fr = (kind_q == PK_BLEND) ? div255(pr_q) : r_q;
    fg = (kind_q == PK_BLEND) ? div255(pg_q) : g_q;
    fb = (kind_q == PK_BLEND) ? div255(pb_q) : b_q;
    nres.src_index = 24'(sid_sum);
    nres.dst_index = didx_q;
    nres.we        = (kind_q != PK_NONE);
    nres.pixel     = 32'd0;
    if (kind_q != PK_NONE) begin
      nres.pixel = ord_q ? {8'hFF, fr, fg, fb} : {8'hFF, fb, fg, fr};
    end
  end

  // Drain the spare first; stage A holds its item while the spare is full.
  logic o_free;
  assign o_free = !o_v_q || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q  <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (o_free) begin
        o_v_q  <= sk_v_q || a_v_q;
        sk_v_q <= 1'b0;
      end else if (a_v_q && !sk_v_q) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free) begin
      if (sk_v_q) begin
        o_q <= sk_q;
      end else begin
        o_q <= nres;
      end
    end else if (a_v_q && !sk_v_q) begin
      sk_q <= nres;
    end
  end

  assign out_valid_o = o_v_q;
  assign res_o       = o_q;

  a_skid_only_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> o_v_q) else $error("spare full while output empty");
  a_we_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && !o_q.we) |-> (o_q.pixel == 32'd0)) else $error("dropped pixel nonzero");
  a_we_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && o_q.we) |-> (o_q.pixel[31:24] == 8'hFF)) else $error("alpha not 255");
endmodule
`default_nettype wire
